// ===== hw/rtl/dhd_pkg.sv =====
// ----------------------------------------------------------------------------
// dhd_pkg
// Shared types and constants for the datagram header deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package dhd_pkg;

  // Defaults for the top-level parameters
  localparam int BUFFER_BYTES_DEF    = 2048;
  localparam int MAX_NAME_LENGTH_DEF = 14;

  // Fixed header layout
  localparam int HEADER_BYTES = 12;
  localparam int SIG_BYTES    = 8;
  localparam int POS_OPCODE   = 8;
  localparam int POS_LEN_LO   = 9;
  localparam int POS_LEN_HI   = 10;
  localparam int POS_NAMES    = 11;

  // Wide enough for length + both names + header (65535 + 15 + 15 + 12)
  localparam int NEED_W = 17;

  // APB register map: 64-bit registers at 8-byte strides
  localparam int APB_DW = 64;
  localparam int APB_AW = 5;
  localparam int REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_SIGNATURE   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_PAYLOAD_LIM = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_MIN_SENDER  = 2'd2;

  localparam logic [63:0] SIGNATURE_RST  = 64'h0B0E_0E0F_0C0A_0C0A;
  localparam logic [15:0] PAYLOAD_LIMRST = 16'd2036;
  localparam logic [3:0]  MIN_SENDER_RST = 4'd3;

  // Byte kinds
  localparam logic [2:0] KIND_HEADER    = 3'd0;
  localparam logic [2:0] KIND_SENDER    = 3'd1;
  localparam logic [2:0] KIND_RECIPIENT = 3'd2;
  localparam logic [2:0] KIND_PAYLOAD   = 3'd3;
  localparam logic [2:0] KIND_IGNORED   = 3'd4;

  // Frame status codes
  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_SHORT     = 3'd1;
  localparam logic [2:0] STAT_BAD_SIG   = 3'd2;
  localparam logic [2:0] STAT_BAD_NAMES = 3'd3;
  localparam logic [2:0] STAT_OVERSIZE  = 3'd4;
  localparam logic [2:0] STAT_TRUNCATED = 3'd5;

  typedef struct packed {
    logic [63:0] signature_word;
    logic [15:0] payload_limit;
    logic [3:0]  min_sender_length;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  byte_value;
    logic [2:0]  byte_kind;
    logic [7:0]  opcode_field;
    logic [15:0] payload_length;
    logic [3:0]  sender_length;
    logic [3:0]  recipient_length;
    logic        frame_done;
    logic [2:0]  frame_status;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dhd_cfg.sv =====
// ----------------------------------------------------------------------------
// dhd_cfg
// APB register file: signature, payload limit and minimum sender length.
// ----------------------------------------------------------------------------
`default_nettype none

module dhd_cfg
  import dhd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  cfg_t                 cfg_r;
  cfg_t                 cfg_nxt;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[APB_AW-1:APB_AW-REG_IDX_W];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_SIGNATURE:   cfg_nxt.signature_word    = pwdata;
        REG_PAYLOAD_LIM: cfg_nxt.payload_limit     = pwdata[15:0];
        REG_MIN_SENDER:  cfg_nxt.min_sender_length = pwdata[3:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.signature_word    <= SIGNATURE_RST;
      cfg_r.payload_limit     <= PAYLOAD_LIMRST;
      cfg_r.min_sender_length <= MIN_SENDER_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SIGNATURE:   prdata = cfg_r.signature_word;
      REG_PAYLOAD_LIM: prdata = {{(APB_DW-16){1'b0}}, cfg_r.payload_limit};
      REG_MIN_SENDER:  prdata = {{(APB_DW-4){1'b0}}, cfg_r.min_sender_length};
      default:         prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== hw/rtl/dhd_parse.sv =====
// ----------------------------------------------------------------------------
// dhd_parse
// Per-datagram state and the byte classifier / status logic.
// ----------------------------------------------------------------------------
`default_nettype none

module dhd_parse
  import dhd_pkg::*;
#(
  parameter int BUFFER_BYTES    = BUFFER_BYTES_DEF,
  parameter int MAX_NAME_LENGTH = MAX_NAME_LENGTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       fire,
  input  wire cfg_t       cfg,
  input  wire logic [7:0] data_byte,
  input  wire logic       end_of_datagram,
  output result_t         res
);

  localparam int CW = $clog2(BUFFER_BYTES + 1);

  logic [CW-1:0] count_r,   count_nxt;
  logic [7:0]    opcode_r,  opcode_nxt;
  logic [15:0]   length_r,  length_nxt;
  logic [3:0]    slen_r,    slen_nxt;
  logic [3:0]    rlen_r,    rlen_nxt;
  logic          sig_bad_r, sig_bad_nxt;

  logic              in_buf;
  logic [CW-1:0]     count_upd;
  logic [63:0]       sig_shift;
  logic [CW-1:0]     body_pos;
  logic [NEED_W-1:0] q_ext;
  logic [NEED_W-1:0] s_end;
  logic [NEED_W-1:0] r_end;
  logic [NEED_W-1:0] p_end;
  logic [NEED_W-1:0] need;
  logic [NEED_W-1:0] got;
  logic              names_bad;
  logic [2:0]        kind;
  logic [2:0]        status;

  assign in_buf    = count_r < CW'(BUFFER_BYTES);
  assign count_upd = in_buf ? count_r + CW'(1) : count_r;

  // byte 0 sits in bits 63..56
  assign sig_shift = cfg.signature_word >> {~count_r[2:0], 3'b000};

  assign body_pos = count_r - CW'(HEADER_BYTES);
  assign q_ext    = {{(NEED_W-CW){1'b0}}, body_pos};
  assign s_end    = {{(NEED_W-4){1'b0}}, slen_r};
  assign r_end    = s_end + {{(NEED_W-4){1'b0}}, rlen_r};
  assign p_end    = r_end + {{(NEED_W-16){1'b0}}, length_r};

  always_comb begin
    opcode_nxt  = opcode_r;
    length_nxt  = length_r;
    slen_nxt    = slen_r;
    rlen_nxt    = rlen_r;
    sig_bad_nxt = sig_bad_r;
    kind        = KIND_IGNORED;
    if (count_r < CW'(SIG_BYTES)) begin
      kind = KIND_HEADER;
      if (sig_shift[7:0] != data_byte) begin
        sig_bad_nxt = 1'b1;
      end
    end else if (count_r == CW'(POS_OPCODE)) begin
      kind       = KIND_HEADER;
      opcode_nxt = data_byte;
    end else if (count_r == CW'(POS_LEN_LO)) begin
      kind       = KIND_HEADER;
      length_nxt = {length_r[15:8], data_byte};
    end else if (count_r == CW'(POS_LEN_HI)) begin
      kind       = KIND_HEADER;
      length_nxt = {data_byte, length_r[7:0]};
    end else if (count_r == CW'(POS_NAMES)) begin
      kind     = KIND_HEADER;
      slen_nxt = data_byte[3:0];
      rlen_nxt = data_byte[7:4];
    end else if (in_buf) begin
      if (q_ext < s_end) begin
        kind = KIND_SENDER;
      end else if (q_ext < r_end) begin
        kind = KIND_RECIPIENT;
      end else if (q_ext < p_end) begin
        kind = KIND_PAYLOAD;
      end else begin
        kind = KIND_IGNORED;
      end
    end
  end

  // Verdict uses the header as updated by this byte
  assign got  = {{(NEED_W-CW){1'b0}}, count_upd};
  assign need = {{(NEED_W-16){1'b0}}, length_nxt} + {{(NEED_W-4){1'b0}}, slen_nxt}
              + {{(NEED_W-4){1'b0}}, rlen_nxt} + NEED_W'(HEADER_BYTES);
  assign names_bad = (rlen_nxt > 4'(MAX_NAME_LENGTH)) || (slen_nxt > 4'(MAX_NAME_LENGTH))
                   || (slen_nxt < cfg.min_sender_length);

  always_comb begin
    if (count_upd < CW'(HEADER_BYTES)) begin
      status = STAT_SHORT;
    end else if (sig_bad_nxt) begin
      status = STAT_BAD_SIG;
    end else if (names_bad) begin
      status = STAT_BAD_NAMES;
    end else if (length_nxt >= cfg.payload_limit) begin
      status = STAT_OVERSIZE;
    end else if (got < need) begin
      status = STAT_TRUNCATED;
    end else begin
      status = STAT_OK;
    end
  end

  assign count_nxt = count_upd;

  always_comb begin
    res.byte_value       = data_byte;
    res.byte_kind        = kind;
    res.opcode_field     = opcode_nxt;
    res.payload_length   = length_nxt;
    res.sender_length    = slen_nxt;
    res.recipient_length = rlen_nxt;
    res.frame_done       = end_of_datagram;
    res.frame_status     = end_of_datagram ? status : STAT_OK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      opcode_r  <= '0;
      length_r  <= '0;
      slen_r    <= '0;
      rlen_r    <= '0;
      sig_bad_r <= 1'b0;
    end else if (fire) begin
      if (end_of_datagram) begin
        count_r   <= '0;
        opcode_r  <= '0;
        length_r  <= '0;
        slen_r    <= '0;
        rlen_r    <= '0;
        sig_bad_r <= 1'b0;
      end else begin
        count_r   <= count_nxt;
        opcode_r  <= opcode_nxt;
        length_r  <= length_nxt;
        slen_r    <= slen_nxt;
        rlen_r    <= rlen_nxt;
        sig_bad_r <= sig_bad_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/datagram_header_deframer.sv =====
// ----------------------------------------------------------------------------
// datagram_header_deframer
// Byte-stream datagram header parser with per-byte tagging and frame status.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one datagram byte per
//   transaction, with in_end_of_datagram set on the final byte. Output
//   channel (out_valid / out_stall) returns one result per input byte: the
//   byte, its kind, the header fields parsed so far, and on the final byte
//   frame_done with the frame status.
//   A byte accepted into the input register moves on into the result
//   register, where out_valid rises; the classifier and status compare
//   sit between those two registers. Throughput is one byte per cycle
//   while out_stall stays low.
//   When out_stall is held, the result register keeps its transaction and
//   one more byte is taken into the input register if it is empty; after
//   that in_stall rises until the result is taken.
//   Reset (rst_n low, synchronous) empties both registers, clears the
//   datagram state and loads the register defaults. Configuration is
//   written over the APB port (64-bit registers at 8-byte strides).
// ----------------------------------------------------------------------------
`default_nettype none

module datagram_header_deframer
  import dhd_pkg::*;
#(
  parameter int BUFFER_BYTES    = BUFFER_BYTES_DEF,
  parameter int MAX_NAME_LENGTH = MAX_NAME_LENGTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input channel
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        in_data_byte,
  input  wire logic              in_end_of_datagram,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [7:0]             out_byte_value,
  output logic [2:0]             out_byte_kind,
  output logic [7:0]             out_opcode_field,
  output logic [15:0]            out_payload_length,
  output logic [3:0]             out_sender_length,
  output logic [3:0]             out_recipient_length,
  output logic                   out_frame_done,
  output logic [2:0]             out_frame_status,
  // configuration
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  cfg_t    cfg;
  result_t res;

  logic       a_valid_r, a_valid_nxt;
  logic [7:0] a_byte_r;
  logic       a_eod_r;
  logic       o_valid_r, o_valid_nxt;
  result_t    o_res_r;
  logic       advance;
  logic       in_take;

  dhd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dhd_parse #(
    .BUFFER_BYTES    (BUFFER_BYTES),
    .MAX_NAME_LENGTH (MAX_NAME_LENGTH)
  ) u_parse (
    .clk             (clk),
    .rst_n           (rst_n),
    .fire            (advance),
    .cfg             (cfg),
    .data_byte       (a_byte_r),
    .end_of_datagram (a_eod_r),
    .res             (res)
  );

  // Move a byte into the result register whenever that slot is free or draining
  assign advance  = a_valid_r & (~o_valid_r | ~out_stall);
  assign in_stall = a_valid_r & ~advance;
  assign in_take  = in_valid & ~in_stall;

  assign a_valid_nxt = in_take | (a_valid_r & ~advance);
  assign o_valid_nxt = advance | (o_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
      o_valid_r <= o_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      a_byte_r <= in_data_byte;
      a_eod_r  <= in_end_of_datagram;
    end
    if (advance) begin
      o_res_r <= res;
    end
  end

  assign out_valid            = o_valid_r;
  assign out_byte_value       = o_res_r.byte_value;
  assign out_byte_kind        = o_res_r.byte_kind;
  assign out_opcode_field     = o_res_r.opcode_field;
  assign out_payload_length   = o_res_r.payload_length;
  assign out_sender_length    = o_res_r.sender_length;
  assign out_recipient_length = o_res_r.recipient_length;
  assign out_frame_done       = o_res_r.frame_done;
  assign out_frame_status     = o_res_r.frame_status;

endmodule

`default_nettype wire
